>>> sv/rtlm_pkg.sv
// shared types and constants for the round trip latency meter
package rtlm_pkg;

  localparam int SampleW  = 16;
  localparam int PsumW    = 29;
  localparam int PeriodW  = 14;
  localparam int PosW     = 13;
  localparam int RateW    = 18;
  localparam int LeadW    = 17;
  localparam int ElW      = 24;
  localparam int NoiseW   = 34;
  localparam int ThrW     = 18;
  localparam int MsW      = 14;
  localparam int CntW     = 5;
  localparam int NumW     = 64;
  localparam int DenW     = 40;
  localparam int CfgIdxW  = 2;

  localparam logic [PeriodW-1:0] NoLoud    = 14'h3FFF;
  localparam logic [PeriodW-1:0] PeriodMax = 14'd8192;
  localparam logic [18:0]        Gain16dB  = 19'd413504;
  localparam logic [ThrW-1:0]    ThrMax    = 18'h3FFFF;
  localparam logic [MsW-1:0]     MsMax     = 14'h3FFF;

  localparam logic [CfgIdxW-1:0] CFG_RATE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEAD   = 2'd2;

  localparam logic [2:0] PH_SKIP    = 3'd0;
  localparam logic [2:0] PH_NOISE   = 3'd1;
  localparam logic [2:0] PH_LISTEN  = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_SUCCESS = 3'd4;
  localparam logic [2:0] PH_FAIL    = 3'd5;

  typedef struct packed {
    logic [PsumW-1:0]   psum;
    logic [PeriodW-1:0] first_loud;
    logic [PeriodW-1:0] period;
  } rec_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

>>> sv/rtlm_front.sv
// front end: per period magnitude sum and first loud sample search
module rtlm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 sample,
  input  logic [rtlm_pkg::PeriodW-1:0] period_len,
  input  logic [rtlm_pkg::ThrW-1:0]   threshold,
  input  logic                        back_done,
  output logic                        push,
  output rtlm_pkg::rec_t              rec
);
  import rtlm_pkg::*;

  logic [PosW-1:0]    pos;
  logic [PsumW-1:0]   psum;
  logic [PeriodW-1:0] first;
  logic               pend;
  logic [PeriodW-1:0] f;
  logic [15:0]        mag;
  logic [PsumW-1:0]   psum_next;
  logic [PeriodW-1:0] first_next;
  logic               loud;
  logic               fire;
  logic               last;

  always_comb begin
    if (period_len == '0) begin
      f = 14'd1;
    end else if (period_len > PeriodMax) begin
      f = PeriodMax;
    end else begin
      f = period_len;
    end
  end

  assign fire       = in_valid && !in_stall;
  assign in_stall   = pend;
  assign mag        = sample[15] ? 16'(-sample) : sample;
  assign psum_next  = psum + PsumW'(mag);
  assign loud       = $signed({{3{sample[15]}}, sample}) > $signed({1'b0, threshold});
  assign first_next = (first == NoLoud && loud) ? PeriodW'(pos) : first;
  assign last       = (PeriodW'(pos) + 14'd1) >= f;
  assign push       = fire && last;
  assign rec        = '{psum: psum_next, first_loud: first_next, period: f};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      psum  <= '0;
      first <= NoLoud;
      pend  <= 1'b0;
    end else begin
      if (back_done) pend <= 1'b0;
      if (fire) begin
        if (last) begin
          pos   <= '0;
          psum  <= '0;
          first <= NoLoud;
          pend  <= 1'b1;
        end else begin
          pos   <= pos + 13'd1;
          psum  <= psum_next;
          first <= first_next;
        end
      end
    end
  end

endmodule

>>> sv/rtlm_queue.sv
// two entry queue of finished period records
module rtlm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rtlm_pkg::rec_t wdata,
  input  logic           pop,
  output logic           empty,
  output rtlm_pkg::rec_t rdata
);
  import rtlm_pkg::*;

  rec_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/rtlm_div.sv
// restoring divider, one quotient bit per cycle
module rtlm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  rtlm_pkg::div_req_t       req,
  output logic                     done,
  output logic [rtlm_pkg::NumW-1:0] quo
);
  import rtlm_pkg::*;

  logic [NumW-1:0] n;
  logic [DenW:0]   rem;
  logic [DenW-1:0] den;
  logic [6:0]      cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem[DenW-1:0], n[NumW-1]};
  assign ge    = trial >= {1'b0, den};
  assign quo   = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'(NumW);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n   <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, den} : trial;
      n   <= {n[NumW-2:0], ge};
    end
  end

endmodule

>>> sv/rtlm_back.sv
// back end: phase sequencer, threshold, latency and result checks
module rtlm_back #(
  parameter int TEST_COUNT       = 5,
  parameter int MAX_WAIT_SECONDS = 5,
  parameter int WAIT_SECONDS     = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  rtlm_pkg::rec_t                q_rec,
  output logic                          q_pop,
  input  logic [rtlm_pkg::RateW-1:0]    sample_rate,
  input  logic [rtlm_pkg::LeadW-1:0]    lead_skip_samples,
  output logic [rtlm_pkg::ThrW-1:0]     threshold,
  output logic                          done,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    phase,
  output logic                          tone_on,
  output logic [4:0]                    test_index,
  output logic                          latency_valid,
  output logic [13:0]                   latency_ms,
  output logic [13:0]                   final_ms,
  output logic [17:0]                   noise_threshold
);
  import rtlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_THR_MUL, S_THR_DIV, S_AVG_DIV, S_MS_START, S_MS_DIV,
    S_SCAN_RD, S_SCAN_ACC, S_FIN_START, S_FIN_DIV, S_OUT
  } state_t;

  localparam logic [CntW-1:0] TestCnt = CntW'(TEST_COUNT);

  state_t             state;
  logic [2:0]         ph;
  logic [ElW-1:0]     el;
  logic [NoiseW-1:0]  noise;
  logic [ThrW-1:0]    thr;
  logic [CntW-1:0]    tc;
  logic [CntW-1:0]    miss;
  logic [MsW-1:0]     fin;
  rec_t               r;
  logic               lat_v;
  logic [MsW-1:0]     lat;
  logic [NumW-1:0]    prod;
  logic [CntW-1:0]    k;
  logic [ElW-1:0]     mx;
  logic [ElW-1:0]     mn;
  logic [PsumW-1:0]   sum;
  logic [ElW-1:0]     mem [16];
  logic [ElW-1:0]     rd;
  div_req_t           dreq;
  logic               ddone;
  logic [NumW-1:0]    dq;
  logic [RateW-1:0]   rate;
  logic [ElW-1:0]     el_f;
  logic [ElW-1:0]     el_n;
  logic [NoiseW-1:0]  noise_n;
  logic [PeriodW-1:0] nmin;
  logic [ElW-1:0]     mx_n;
  logic [ElW-1:0]     mn_n;

  function automatic logic [ElW-1:0] sat_add(input logic [ElW-1:0] a,
                                             input logic [PeriodW-1:0] b);
    logic [ElW:0] t;
    t = {1'b0, a} + (ElW+1)'(b);
    return t[ElW] ? '1 : t[ElW-1:0];
  endfunction

  function automatic logic [MsW-1:0] sat_ms(input logic [NumW-1:0] v);
    return (v > NumW'(MsMax)) ? MsMax : v[MsW-1:0];
  endfunction

  rtlm_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(dq));

  assign rate      = (sample_rate == '0) ? 18'd1 : sample_rate;
  assign el_f      = sat_add(el, r.period);
  assign noise_n   = noise + NoiseW'(r.psum);
  assign nmin      = (r.first_loud < r.period) ? r.first_loud : r.period;
  assign el_n      = sat_add(el, nmin);
  assign mx_n      = (rd > mx) ? rd : mx;
  assign mn_n      = (rd < mn) ? rd : mn;
  assign threshold = thr;
  assign q_pop     = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (state == S_AVG_DIV && ddone && dq > NumW'(thr) && el_n > ElW'(r.period)) begin
      mem[4'(tc - 5'd1)] <= el_n;
    end
    if (state == S_SCAN_RD) rd <= mem[k[3:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= PH_SKIP;
      el        <= '0;
      noise     <= '0;
      thr       <= '0;
      tc        <= 5'd1;
      miss      <= '0;
      fin       <= '0;
      out_valid <= 1'b0;
      done      <= 1'b0;
      dreq      <= '0;
    end else begin
      done       <= 1'b0;
      dreq.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            r     <= q_rec;
            lat_v <= 1'b0;
            lat   <= '0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (ph)
            PH_SKIP: begin
              if (lead_skip_samples != '0) begin
                el <= el_f;
                if (el_f >= ElW'(lead_skip_samples)) begin
                  el <= '0;
                  ph <= PH_NOISE;
                end
                state <= S_OUT;
              end else begin
                el <= '0;
                ph <= PH_NOISE;
              end
            end
            PH_NOISE: begin
              noise <= noise_n;
              el    <= el_f;
              if ((ElW+1)'(el_f) + (ElW+1)'(lead_skip_samples) >= (ElW+1)'(rate)) begin
                prod  <= NumW'(noise_n[16:0] * Gain16dB);
                state <= S_THR_MUL;
              end else begin
                state <= S_OUT;
              end
            end
            PH_LISTEN: begin
              dreq  <= '{start: 1'b1, num: NumW'(r.psum), den: DenW'(r.period)};
              state <= S_AVG_DIV;
            end
            PH_WAIT: begin
              el <= el_f;
              if (28'(el_f) > 28'(rate) * 28'(WAIT_SECONDS)) begin
                el    <= '0;
                noise <= '0;
                ph    <= PH_SKIP;
              end
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_THR_MUL: begin
          dreq  <= '{start: 1'b1,
                     num: prod + (NumW'(noise[33:17] * Gain16dB) << 17),
                     den: DenW'(el)};
          state <= S_THR_DIV;
        end
        S_THR_DIV: begin
          if (ddone) begin
            thr   <= ((dq >> 16) > NumW'(ThrMax)) ? ThrMax : dq[16 +: ThrW];
            ph    <= PH_LISTEN;
            el    <= '0;
            noise <= '0;
            state <= S_OUT;
          end
        end
        S_AVG_DIV: begin
          if (ddone) begin
            if (dq > NumW'(thr)) begin
              if (el_n > ElW'(r.period)) begin
                el    <= el_n;
                lat_v <= 1'b1;
                state <= S_MS_START;
              end else begin
                ph    <= PH_WAIT;
                el    <= '0;
                state <= S_OUT;
              end
            end else begin
              el <= el_f;
              if (28'(el_f) > 28'(rate) * 28'(MAX_WAIT_SECONDS)) begin
                miss <= miss + 5'd1;
                if (miss + 5'd1 > TestCnt) begin
                  ph <= PH_FAIL;
                end else begin
                  ph <= PH_WAIT;
                  el <= '0;
                end
              end
              state <= S_OUT;
            end
          end
        end
        S_MS_START: begin
          dreq  <= '{start: 1'b1, num: NumW'(el * 10'd1000), den: DenW'(rate)};
          state <= S_MS_DIV;
        end
        S_MS_DIV: begin
          if (ddone) begin
            lat   <= sat_ms(dq);
            k     <= '0;
            mx    <= '0;
            mn    <= '1;
            sum   <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_ACC;
        S_SCAN_ACC: begin
          mx  <= mx_n;
          mn  <= mn_n;
          sum <= sum + PsumW'(rd);
          k   <= k + 5'd1;
          if (k + 5'd1 >= tc) begin
            if ({1'b0, mx_n} > {mn_n, 1'b0}) begin
              ph    <= PH_FAIL;
              state <= S_OUT;
            end else if (tc == TestCnt) begin
              state <= S_FIN_START;
            end else begin
              ph    <= PH_WAIT;
              tc    <= tc + 5'd1;
              el    <= '0;
              state <= S_OUT;
            end
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_FIN_START: begin
          dreq  <= '{start: 1'b1, num: NumW'(sum * 10'd1000),
                     den: DenW'(rate * CntW'(TEST_COUNT))};
          state <= S_FIN_DIV;
        end
        S_FIN_DIV: begin
          if (ddone) begin
            fin   <= sat_ms(dq);
            ph    <= PH_SUCCESS;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            phase           <= ph;
            tone_on         <= (ph == PH_LISTEN);
            test_index      <= tc;
            latency_valid   <= lat_v;
            latency_ms      <= lat;
            final_ms        <= fin;
            noise_threshold <= thr;
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/round_trip_latency_meter_top.sv
// top level of the round trip latency meter
// a sample inside a period only updates the running sums; the result of the last sample of a
// period passes through the queue and the back end, which may add a threshold division, or
// three divisions and a scan when a detection ends the last test
// throughput: one sample per cycle inside a period; after the last sample the input
// stalls until the result is loaded into the output register; sync active high reset
module round_trip_latency_meter_top #(
  parameter int TEST_COUNT       = 5,
  parameter int MAX_WAIT_SECONDS = 5,
  parameter int WAIT_SECONDS     = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  phase,
  output logic        tone_on,
  output logic [4:0]  test_index,
  output logic        latency_valid,
  output logic [13:0] latency_ms,
  output logic [13:0] final_ms,
  output logic [17:0] noise_threshold,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import rtlm_pkg::*;

  logic [RateW-1:0]   sample_rate;
  logic [PeriodW-1:0] period_len;
  logic [LeadW-1:0]   lead_skip;
  logic [ThrW-1:0]    thr;
  logic               back_done;
  logic               push;
  rec_t               wrec;
  rec_t               rrec;
  logic               pop;
  logic               empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= 18'd48000;
      period_len  <= 14'd1024;
      lead_skip   <= 17'd10240;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RATE:   sample_rate <= cfg_data;
        CFG_PERIOD: period_len  <= cfg_data[PeriodW-1:0];
        CFG_LEAD:   lead_skip   <= cfg_data[LeadW-1:0];
        default: ;
      endcase
    end
  end

  rtlm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .period_len(period_len), .threshold(thr), .back_done(back_done),
    .push(push), .rec(wrec)
  );

  rtlm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(wrec), .pop(pop), .empty(empty),
    .rdata(rrec)
  );

  rtlm_back #(
    .TEST_COUNT(TEST_COUNT), .MAX_WAIT_SECONDS(MAX_WAIT_SECONDS),
    .WAIT_SECONDS(WAIT_SECONDS)
  ) u_back (
    .clk(clk), .rst(rst), .q_empty(empty), .q_rec(rrec), .q_pop(pop),
    .sample_rate(sample_rate), .lead_skip_samples(lead_skip), .threshold(thr),
    .done(back_done), .out_valid(out_valid), .out_stall(out_stall), .phase(phase),
    .tone_on(tone_on), .test_index(test_index), .latency_valid(latency_valid),
    .latency_ms(latency_ms), .final_ms(final_ms), .noise_threshold(noise_threshold)
  );

endmodule

>>> sv/rtlm_checker.sv
// port level checks for the round trip latency meter
module rtlm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  phase,
  input logic        tone_on,
  input logic        latency_valid,
  input logic [13:0] latency_ms
);
  import rtlm_pkg::*;

  a_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tone_on == (phase == PH_LISTEN)))
    else $error("tone flag disagrees with phase");

  a_lat_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !latency_valid) |-> (latency_ms == 14'd0))
    else $error("latency without valid flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(phase)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind round_trip_latency_meter_top rtlm_checker u_rtlm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .phase(phase),
  .tone_on(tone_on), .latency_valid(latency_valid), .latency_ms(latency_ms)
);

>>> verif/round_trip_latency_meter_top_tb.sv
// testbench for the round trip latency meter: predicted period results against the dut
`timescale 1ns / 1ps

module round_trip_latency_meter_top_tb;
  import rtlm_pkg::*;

  typedef struct packed {
    logic [2:0]  phase;
    logic        tone_on;
    logic [4:0]  test_index;
    logic        latency_valid;
    logic [13:0] latency_ms;
    logic [13:0] final_ms;
    logic [17:0] noise_threshold;
  } period_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  phase;
  logic        tone_on;
  logic [4:0]  test_index;
  logic        latency_valid;
  logic [13:0] latency_ms;
  logic [13:0] final_ms;
  logic [17:0] noise_threshold;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  round_trip_latency_meter_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // meter state as predicted
  int unsigned     rate_cfg, period_cfg, lead_cfg;
  int unsigned     m_phase, m_elapsed, m_pos, m_psum, m_first, m_thr, m_test, m_miss, m_final;
  longint unsigned m_noise;
  int unsigned     m_delays [16];

  logic [15:0]    sample_q [$];
  period_report_t report_q [$];
  int unsigned    n_queued = 0, n_taken = 0;
  int unsigned    n_errors = 0, n_reports = 0, n_latencies = 0;
  bit [7:0]       phases_seen = '0;
  bit             burst = 1'b0;

  function automatic int unsigned eff_rate();
    return rate_cfg == 0 ? 1 : rate_cfg;
  endfunction

  function automatic int unsigned eff_period();
    if (period_cfg == 0) return 1;
    if (period_cfg > 8192) return 8192;
    return period_cfg;
  endfunction

  function automatic void add_elapsed(int unsigned n);
    longint unsigned t;
    t = longint'(m_elapsed) + n;
    m_elapsed = t > 64'hFFFFFF ? 32'hFFFFFF : int'(t);
  endfunction

  function automatic int unsigned ms_of(longint unsigned num, longint unsigned den);
    longint unsigned v;
    v = num / den;
    return v > MsMax ? MsMax : int'(v);
  endfunction

  function automatic void listen_end(int unsigned f, output bit got, output int unsigned ms);
    int unsigned     n, idx, mx, mn;
    longint unsigned sum;
    got = 1'b0;
    ms = 0;
    if (m_psum / f > m_thr) begin
      n = m_first < f ? m_first : f;
      add_elapsed(n);
      if (m_elapsed > f) begin
        idx = (m_test - 1) & 15;
        mx = 0;
        mn = 32'hFFFFFFFF;
        sum = 0;
        m_delays[idx] = m_elapsed;
        got = 1'b1;
        ms = ms_of(longint'(m_elapsed) * 1000, eff_rate());
        for (int k = 0; k < m_test && k < 16; k++) begin
          if (m_delays[k] > mx) mx = m_delays[k];
          if (m_delays[k] < mn) mn = m_delays[k];
          sum += m_delays[k];
        end
        if (longint'(mx) > 2 * longint'(mn)) begin
          m_phase = PH_FAIL;
          return;
        end
        if (m_test == 5) begin
          m_final = ms_of(sum * 1000, longint'(eff_rate()) * 5);
          m_phase = PH_SUCCESS;
          return;
        end
        m_phase = PH_WAIT;
        m_test = (m_test + 1) & 31;
      end else begin
        m_phase = PH_WAIT;
      end
      m_elapsed = 0;
    end else begin
      add_elapsed(f);
      if (longint'(m_elapsed) > longint'(eff_rate()) * 5) begin
        m_miss = (m_miss + 1) & 31;
        if (m_miss > 5) begin
          m_phase = PH_FAIL;
          return;
        end
        m_phase = PH_WAIT;
        m_elapsed = 0;
      end
    end
  endfunction

  function automatic void meter_step(logic [15:0] s_raw, output bit got, output period_report_t r);
    int          s;
    int unsigned f, ms;
    bit          lat;
    logic [2:0]  ph;
    s = int'($signed(s_raw));
    f = eff_period();
    lat = 1'b0;
    ms = 0;
    got = 1'b0;
    r = '0;
    m_psum += s < 0 ? -s : s;
    if (m_first == NoLoud && s > int'(m_thr)) m_first = m_pos;
    if (m_pos + 1 < f) begin
      m_pos++;
      return;
    end
    ph = m_phase;
    if (ph == PH_SKIP) begin
      if (lead_cfg > 0) begin
        add_elapsed(f);
        if (m_elapsed >= lead_cfg) begin
          m_elapsed = 0;
          m_phase = PH_NOISE;
        end
      end else begin
        m_elapsed = 0;
        m_phase = PH_NOISE;
      end
    end
    if (!(ph == PH_SKIP && lead_cfg > 0)) begin
      if (m_phase == PH_NOISE) begin
        m_noise += m_psum;
        add_elapsed(f);
        if (longint'(m_elapsed) >= longint'(eff_rate()) - longint'(lead_cfg)) begin
          m_noise = (m_noise * Gain16dB) / (longint'(m_elapsed) * 65536);
          m_thr = m_noise > ThrMax ? ThrMax : int'(m_noise);
          m_phase = PH_LISTEN;
          m_elapsed = 0;
          m_noise = 0;
        end
      end else if (m_phase == PH_LISTEN) begin
        listen_end(f, lat, ms);
      end else if (m_phase == PH_WAIT) begin
        add_elapsed(f);
        if (longint'(m_elapsed) > longint'(eff_rate()) * 3) begin
          m_elapsed = 0;
          m_noise = 0;
          m_phase = PH_SKIP;
        end
      end
    end
    m_pos = 0;
    m_psum = 0;
    m_first = NoLoud;
    got = 1'b1;
    r.phase = m_phase[2:0];
    r.tone_on = m_phase == PH_LISTEN;
    r.test_index = m_test[4:0];
    r.latency_valid = lat;
    r.latency_ms = ms[13:0];
    r.final_ms = m_final[13:0];
    r.noise_threshold = m_thr[17:0];
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // request acceptance and prediction
  bit          took = 1'b0;
  int unsigned in_gap = 0, out_gap = 0;

  always @(posedge clk) begin
    period_report_t r;
    bit             got;
    took = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      took = 1'b1;
      n_taken++;
      meter_step(sample, got, r);
      if (got) report_q.push_back(r);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) burst <= ~burst;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample <= sample_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_gap <= gap_len();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    period_report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {phase, tone_on, test_index, latency_valid, latency_ms, final_ms, noise_threshold};
      n_reports++;
      phases_seen[phase] = 1'b1;
      if (latency_valid) n_latencies++;
      if (report_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected period result %h", got);
      end else begin
        want = report_q.pop_front();
        if (got.phase !== want.phase || got.tone_on !== want.tone_on ||
            got.test_index !== want.test_index || got.latency_valid !== want.latency_valid ||
            got.latency_ms !== want.latency_ms || got.final_ms !== want.final_ms ||
            got.noise_threshold !== want.noise_threshold) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: period %0d expected ph=%0d tone=%0b test=%0d lv=%0b ms=%0d fin=%0d thr=%0d got ph=%0d tone=%0b test=%0d lv=%0b ms=%0d fin=%0d thr=%0d",
                     n_reports, want.phase, want.tone_on, want.test_index, want.latency_valid,
                     want.latency_ms, want.final_ms, want.noise_threshold, got.phase, got.tone_on,
                     got.test_index, got.latency_valid, got.latency_ms, got.final_ms,
                     got.noise_threshold);
        end
      end
    end
  end

  task automatic push_sample(logic [15:0] v);
    sample_q.push_back(v);
    n_queued++;
  endtask

  task automatic drain();
    while (n_taken != n_queued || report_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[17:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RATE:   rate_cfg = v & 18'h3FFFF;
      CFG_PERIOD: period_cfg = v & 14'h3FFF;
      CFG_LEAD:   lead_cfg = v & 17'h1FFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one period: quiet noise with loud samples from onset on, onset >= f means none; wild gives random samples
  task automatic push_period(int unsigned onset, bit wild);
    int unsigned f;
    f = eff_period();
    for (int unsigned i = 0; i < f; i++) begin
      if (wild) push_sample(16'($urandom_range(0, 65535)));
      else if (i >= onset) push_sample(16'(16000 + $urandom_range(0, 16767)));
      else push_sample(16'($urandom_range(0, 80) - 40));
    end
  endtask

  initial begin
    int unsigned f, on, next_cfg, r;
    bit          miss_mode, early;
    rate_cfg = 48000;
    period_cfg = 1024;
    lead_cfg = 10240;
    m_phase = PH_SKIP;
    m_elapsed = 0;
    m_pos = 0;
    m_psum = 0;
    m_first = NoLoud;
    m_noise = 0;
    m_thr = 0;
    m_test = 1;
    m_miss = 0;
    m_final = 0;
    foreach (m_delays[i]) m_delays[i] = 0;
    miss_mode = 1'b0;
    early = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes of the sample inside a long default period
    push_sample(16'h8000); push_sample(16'h7FFF); push_sample(16'h0000);
    push_sample(16'hFFFF); push_sample(16'h0001); push_sample(16'h5555);
    push_sample(16'hAAAA); push_sample(16'h8001); push_sample(16'h7FFE);
    push_sample(16'h00FF); push_sample(16'hFF00); push_sample(16'h0F0F);
    push_sample(16'hF0F0); push_sample(16'h3333); push_sample(16'hCCCC);
    push_sample(16'h7FFF); push_sample(16'h8000); push_sample(16'h0000);
    drain();
    // period shrinks below the current position, ends on the next sample
    write_reg(CFG_PERIOD, 16);
    write_reg(CFG_LEAD, 65536);
    write_reg(CFG_RATE, 192000);
    push_sample(16'h1234);
    drain();
    write_reg(CFG_RATE, 8000);
    push_period(16, 1'b0);
    drain();
    // zero lead skip passes straight into noise measurement
    write_reg(CFG_LEAD, 0);
    write_reg(CFG_RATE, 32);
    next_cfg = 600;

    while (n_queued < 1850) begin
      while (n_taken != n_queued) @(posedge clk);
      if (n_queued >= next_cfg && m_phase < PH_SUCCESS) begin
        drain();
        r = $urandom_range(16, 48);
        write_reg(CFG_RATE, r);
        write_reg(CFG_PERIOD, $urandom_range(16, 32));
        write_reg(CFG_LEAD, $urandom_range(0, 1) ? r : r + 16 * $urandom_range(0, 2));
        next_cfg += 600;
      end
      f = eff_period();
      if (m_phase == PH_LISTEN) begin
        if (m_elapsed == 0) begin
          miss_mode = $urandom_range(0, 6) == 0;
          early = $urandom_range(0, 5) == 0;
        end
        if (miss_mode) begin
          push_period(f, 1'b0);
        end else if (early && m_elapsed == 0) begin
          push_period($urandom_range(0, f - 2), 1'b0);
        end else if (m_elapsed >= 2 * f) begin
          on = 3 * f > m_elapsed ? 3 * f - m_elapsed : 0;
          push_period($urandom_range(0, on < f ? on : f - 1), 1'b0);
        end else begin
          push_period(f, 1'b0);
        end
      end else begin
        push_period(f, m_phase >= PH_SUCCESS);
      end
    end

    drain();
    write_reg(CFG_PERIOD, 0);
    repeat (6) push_sample(16'($urandom_range(0, 65535)));
    drain();
    // oversized period is clamped, so a short burst ends no period
    write_reg(CFG_RATE, 0);
    write_reg(CFG_LEAD, 131071);
    write_reg(CFG_PERIOD, 16383);
    repeat (40) push_sample(16'($urandom_range(0, 65535)));

    while (n_taken != n_queued || report_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run covered %0d samples, %0d period results, %0d round trip measurements",
             n_taken, n_reports, n_latencies);
    $display("phases reached %b, final phase %0d, %0d failures", phases_seen, m_phase, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ERROR: timeout with %0d results outstanding", report_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
